// ----- hw/rtl/madt_pkg.sv -----
// Shared constants and types for the interrupt-controller table entry parser.
package madt_pkg;

	localparam int CNT_W       = 4;
	localparam int FIELD_BYTES = 9;
	localparam int MAX_IDS_DEF = 8;

	localparam logic [31:0] DEF_LOCAL_BASE = 32'hFEE0_0000;

	// entry type codes
	localparam logic [7:0] KIND_LAPIC     = 8'd0;
	localparam logic [7:0] KIND_IOAPIC    = 8'd1;
	localparam logic [7:0] KIND_LAPIC_OVR = 8'd5;

	// length limits
	localparam logic [7:0] LEN_MIN        = 8'd2;
	localparam logic [7:0] LEN_LAPIC_MIN  = 8'd8;
	localparam logic [7:0] LEN_IOAPIC_MIN = 8'd12;
	localparam logic [7:0] LEN_OVR_MIN    = 8'd12;

	// byte positions inside an entry
	localparam logic [7:0] POS_KIND    = 8'd0;
	localparam logic [7:0] POS_LEN     = 8'd1;
	localparam logic [7:0] POS_BODY    = 8'd2;
	localparam logic [7:0] POS_FIELD0  = 8'd3;
	localparam logic [7:0] POS_FIELD_Z = 8'd11;

	// configuration register index (paddr[2])
	localparam logic REG_DEFAULT_BASE = 1'b0;

	// one completed entry, as seen by the accumulator
	typedef struct packed {
		logic        done;
		logic [7:0]  kind;
		logic [7:0]  length;
		logic [7:0]  cpu_id;
		logic        enabled;
		logic [63:0] field;
	} entry_evt_t;

	typedef struct packed {
		logic             status;
		logic [63:0]      local_base;
		logic [31:0]      router_base;
		logic [31:0]      router_irq_base;
		logic [CNT_W-1:0] cpu_count;
		logic [63:0]      cpu_ids;
	} summary_t;

endpackage

// ----- hw/rtl/madt_entry_seq.sv -----
// Entry framing: tracks type, length and byte position, captures body bytes.
module madt_entry_seq import madt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic       byte_in_valid,
	input  logic [7:0] byte_in,
	input  logic       clear,
	output entry_evt_t evt
);

	logic [7:0] kind_q, len_q, pos_q;
	logic       stopped_q;
	logic [7:0] fb_q [FIELD_BYTES];

	logic [7:0] kind_n, len_n, pos_n;
	logic       stop_n;
	logic       take;
	logic [8:0] pos_inc;

	assign take    = fire & byte_in_valid & ~stopped_q;
	assign pos_inc = {1'b0, pos_q} + 9'd1;

	always_comb begin
		kind_n      = kind_q;
		len_n       = len_q;
		pos_n       = pos_q;
		stop_n      = stopped_q;
		evt.done    = 1'b0;
		evt.kind    = kind_q;
		evt.length  = len_q;
		evt.cpu_id  = fb_q[0];
		evt.enabled = fb_q[1][0];
		// last body byte may complete the field in this same transfer
		evt.field   = {((take && pos_q == POS_FIELD_Z) ? byte_in : fb_q[8]),
			fb_q[7], fb_q[6], fb_q[5], fb_q[4], fb_q[3], fb_q[2], fb_q[1]};
		if (take) begin
			if (pos_q == POS_KIND) begin
				kind_n = byte_in;
				pos_n  = POS_LEN;
			end else if (pos_q == POS_LEN) begin
				if (byte_in < LEN_MIN) begin
					stop_n = 1'b1;
				end else begin
					len_n      = byte_in;
					evt.length = byte_in;
					if (byte_in == LEN_MIN) begin
						evt.done = 1'b1;
						pos_n    = POS_KIND;
					end else begin
						pos_n = POS_BODY;
					end
				end
			end else if (pos_inc >= {1'b0, len_q}) begin
				evt.done = 1'b1;
				pos_n    = POS_KIND;
			end else begin
				pos_n = pos_inc[7:0];
			end
		end
		if (clear) begin
			kind_n = '0;
			len_n  = '0;
			pos_n  = POS_KIND;
			stop_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= '0;
			len_q     <= '0;
			pos_q     <= POS_KIND;
			stopped_q <= 1'b0;
		end else begin
			kind_q    <= kind_n;
			len_q     <= len_n;
			pos_q     <= pos_n;
			stopped_q <= stop_n;
		end
	end

	// capture body bytes at offsets 3..11
	always_ff @(posedge clk) begin
		for (int k = 0; k < FIELD_BYTES; k++) begin
			if (take && pos_q >= POS_FIELD0 && pos_q == POS_FIELD0 + 8'(k))
				fb_q[k] <= byte_in;
		end
	end

endmodule

// ----- hw/rtl/madt_accum.sv -----
// Table summary: collects ids, routing controller and local base; holds the result.
module madt_accum import madt_pkg::*; #(
	parameter int MAX_IDS = MAX_IDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_evt_t  evt,
	input  logic        finish,
	input  logic [31:0] default_base,
	input  logic        out_ready,
	output logic        out_valid,
	output summary_t    result
);

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [7:0]       ids_q [MAX_IDS];
	logic [7:0]       ids_n [MAX_IDS];
	logic             found_q, found_n;
	logic [31:0]      rbase_q, rbase_n, rirq_q, rirq_n;
	logic             seen_q, seen_n;
	logic [63:0]      ovr_q, ovr_n;
	logic             wr_id;
	logic             out_valid_q;
	summary_t         res_q, res_n;

	always_comb begin
		cnt_n   = cnt_q;
		found_n = found_q;
		rbase_n = rbase_q;
		rirq_n  = rirq_q;
		seen_n  = seen_q;
		ovr_n   = ovr_q;
		wr_id   = 1'b0;
		if (evt.done) begin
			case (evt.kind)
				KIND_LAPIC: begin
					if (evt.length >= LEN_LAPIC_MIN && evt.enabled &&
						cnt_q < CNT_W'(MAX_IDS)) begin
						wr_id = 1'b1;
						cnt_n = cnt_q + CNT_W'(1);
					end
				end
				KIND_IOAPIC: begin
					if (evt.length >= LEN_IOAPIC_MIN && !found_q) begin
						found_n = 1'b1;
						rbase_n = evt.field[31:0];
						rirq_n  = evt.field[63:32];
					end
				end
				KIND_LAPIC_OVR: begin
					if (evt.length >= LEN_OVR_MIN) begin
						seen_n = 1'b1;
						ovr_n  = evt.field;
					end
				end
				default: ;
			endcase
		end
		for (int i = 0; i < MAX_IDS; i++)
			ids_n[i] = (wr_id && cnt_q == CNT_W'(i)) ? evt.cpu_id : ids_q[i];
	end

	always_comb begin
		res_n.status          = ~found_n;
		res_n.local_base      = seen_n ? ovr_n : {32'b0, default_base};
		res_n.router_base     = rbase_n;
		res_n.router_irq_base = rirq_n;
		res_n.cpu_count       = cnt_n;
		res_n.cpu_ids         = '0;
		for (int i = 0; i < MAX_IDS; i++) begin
			if (CNT_W'(i) < cnt_n)
				res_n.cpu_ids[8*i +: 8] = ids_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			found_q     <= 1'b0;
			rbase_q     <= '0;
			rirq_q      <= '0;
			seen_q      <= 1'b0;
			ovr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
				rbase_q <= '0;
				rirq_q  <= '0;
				seen_q  <= 1'b0;
				ovr_q   <= '0;
			end else begin
				cnt_q   <= cnt_n;
				found_q <= found_n;
				rbase_q <= rbase_n;
				rirq_q  <= rirq_n;
				seen_q  <= seen_n;
				ovr_q   <= ovr_n;
			end
			if (finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_IDS; i++)
			ids_q[i] <= ids_n[i];
		if (finish)
			res_q <= res_n;
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_IDS))
		else $error("id count above limit");

	a_clear_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (cnt_q == '0 && !found_q && !seen_q))
		else $error("summary state not cleared after end of table");

	a_no_router_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status) |->
			(res_q.router_base == '0 && res_q.router_irq_base == '0))
		else $error("router fields set without routing controller");

	a_out_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.cpu_count <= CNT_W'(MAX_IDS))
		else $error("result id count above limit");

endmodule

// ----- hw/rtl/madt_entry_parser_top.sv -----
// Top level of the interrupt-controller table entry parser.
// Feed the entry area one byte per transfer on the input channel (little
// endian, is_last on the final transfer, byte_valid low for a bare end
// marker). Each byte is taken into an input register and handled from
// there, so one byte is accepted every cycle; the summary is built when
// the is_last transfer leaves the input register and is held in an output
// register, and the input keeps flowing unless a second end of table
// arrives while an earlier summary is still untaken. After each summary
// all collected state is cleared. default_local_base sits at APB address 0
// and should be written only while no table is in flight.
module madt_entry_parser_top import madt_pkg::*; #(
	parameter int MAX_IDS = MAX_IDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       entry_byte,
	input  logic             byte_valid,
	input  logic             is_last,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             status,
	output logic [63:0]      local_base,
	output logic [31:0]      router_base,
	output logic [31:0]      router_irq_base,
	output logic [CNT_W-1:0] cpu_count,
	output logic [63:0]      cpu_ids,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic        v_s1, bvalid_s1, last_s1;
	logic [7:0]  byte_s1;
	logic        stall, fire, finish;
	logic [31:0] dflt_q;
	entry_evt_t  evt;
	summary_t    result;

	// hold an end-of-table byte until the previous summary is taken
	assign stall    = v_s1 & last_s1 & out_valid & ~out_ready;
	assign fire     = v_s1 & ~stall;
	assign finish   = fire & last_s1;
	assign in_ready = ~v_s1 | ~stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1   <= entry_byte;
			bvalid_s1 <= byte_valid;
			last_s1   <= is_last;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q <= DEF_LOCAL_BASE;
		end else if (psel && penable && pwrite && paddr[2] == REG_DEFAULT_BASE) begin
			dflt_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DEFAULT_BASE) ? dflt_q : 32'b0;

	madt_entry_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.byte_in_valid (bvalid_s1),
		.byte_in       (byte_s1),
		.clear         (finish),
		.evt           (evt)
	);

	madt_accum #(
		.MAX_IDS (MAX_IDS)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt          (evt),
		.finish       (finish),
		.default_base (dflt_q),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.result       (result)
	);

	assign status          = result.status;
	assign local_base      = result.local_base;
	assign router_base     = result.router_base;
	assign router_irq_base = result.router_irq_base;
	assign cpu_count       = result.cpu_count;
	assign cpu_ids         = result.cpu_ids;

endmodule

// ----- tb/sv/tb_madt_entry_parser_top.sv -----
// Self-checking testbench for the interrupt-controller table entry parser top level.
`timescale 1ns / 1ps

module tb_madt_entry_parser_top;
	import madt_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_BYTES = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PRINT_LIMIT  = 40;
	localparam logic [2:0] ADDR_DEFAULT_BASE = {REG_DEFAULT_BASE, 2'b00};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       entry_byte = 8'h00;
	logic             byte_valid = 1'b0;
	logic             is_last = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             status;
	logic [63:0]      local_base;
	logic [31:0]      router_base;
	logic [31:0]      router_irq_base;
	logic [CNT_W-1:0] cpu_count;
	logic [63:0]      cpu_ids;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [2:0]       paddr = 3'd0;
	logic [31:0]      pwdata = 32'h0;
	logic [31:0]      prdata;
	logic             pready;

	madt_entry_parser_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.entry_byte(entry_byte), .byte_valid(byte_valid), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .local_base(local_base), .router_base(router_base),
		.router_irq_base(router_irq_base), .cpu_count(cpu_count), .cpu_ids(cpu_ids),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// parser image
	logic [31:0]      cfg_default_base = DEF_LOCAL_BASE;
	logic [7:0]       p_kind = '0;
	logic [7:0]       p_len = '0;
	logic [7:0]       p_pos = '0;
	logic [8:0][7:0]  p_fields = '0;
	logic             p_stopped = 1'b0;
	logic             p_found = 1'b0;
	logic [63:0]      p_ovr_base = '0;
	logic             p_ovr_seen = 1'b0;
	logic [31:0]      p_rbase = '0;
	logic [31:0]      p_rirq = '0;
	logic [CNT_W-1:0] p_count = '0;
	logic [7:0][7:0]  p_ids = '0;

	summary_t   pending_summaries[$];
	logic [7:0] table_bytes[$];
	int         stall_pct = 15;
	int         bytes_sent = 0;
	int         mismatches = 0;
	int         idle_cycles = 0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch on %s, got %h, want %h", what, got, want);
		mismatches++;
	endtask

	function automatic void close_entry();
		if (p_kind == KIND_LAPIC) begin
			if (p_len >= LEN_LAPIC_MIN && p_fields[1][0] && p_count < MAX_IDS_DEF) begin
				p_ids[p_count[2:0]] = p_fields[0];
				p_count++;
			end
		end else if (p_kind == KIND_IOAPIC) begin
			if (p_len >= LEN_IOAPIC_MIN && !p_found) begin
				p_rbase = p_fields[4:1];
				p_rirq  = p_fields[8:5];
				p_found = 1'b1;
			end
		end else if (p_kind == KIND_LAPIC_OVR) begin
			if (p_len >= LEN_OVR_MIN) begin
				p_ovr_base = p_fields[8:1];
				p_ovr_seen = 1'b1;
			end
		end
	endfunction

	function automatic void absorb_byte(input logic [7:0] b, input logic bv, input logic last);
		summary_t s;
		if (bv && !p_stopped) begin
			if (p_pos == POS_KIND) begin
				p_kind   = b;
				p_fields = '0;
				p_pos    = POS_LEN;
			end else if (p_pos == POS_LEN) begin
				if (b < LEN_MIN) begin
					p_stopped = 1'b1;
				end else begin
					p_len = b;
					if (b == LEN_MIN) begin
						close_entry();
						p_pos = POS_KIND;
					end else begin
						p_pos = POS_BODY;
					end
				end
			end else begin
				if (p_pos >= POS_FIELD0 && p_pos <= POS_FIELD_Z)
					p_fields[p_pos - POS_FIELD0] = b;
				if ({1'b0, p_pos} + 9'd1 >= {1'b0, p_len}) begin
					close_entry();
					p_pos = POS_KIND;
				end else begin
					p_pos++;
				end
			end
		end
		if (last) begin
			s.status          = !p_found;
			s.local_base      = p_ovr_seen ? p_ovr_base : {32'h0, cfg_default_base};
			s.router_base     = p_rbase;
			s.router_irq_base = p_rirq;
			s.cpu_count       = p_count;
			s.cpu_ids         = p_ids;
			pending_summaries.push_back(s);
			p_kind = '0; p_len = '0; p_pos = '0; p_fields = '0;
			p_stopped = 1'b0; p_found = 1'b0; p_ovr_base = '0; p_ovr_seen = 1'b0;
			p_rbase = '0; p_rirq = '0; p_count = '0; p_ids = '0;
		end
	endfunction

	task automatic send_item(input logic [7:0] b, input logic bv, input logic last);
		while ($urandom_range(99) < stall_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		entry_byte <= b;
		byte_valid <= bv;
		is_last    <= last;
		do @(posedge clk); while (!in_ready);
		absorb_byte(b, bv, last);
		if (bv)
			bytes_sent++;
	endtask

	task automatic push_entry(input logic [7:0] kind, input logic [7:0] len,
			input logic [95:0] body);
		table_bytes.push_back(kind);
		table_bytes.push_back(len);
		for (int p = 2; p < len; p++)
			table_bytes.push_back(p < 12 ? body[8*p +: 8] : 8'($urandom));
	endtask

	task automatic send_table(input bit bare);
		int n;
		n = table_bytes.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 4)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(table_bytes[i], 1'b1, !bare && i == n - 1);
		end
		if (bare || n == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
		table_bytes.delete();
	endtask

	// park the input and let the last summary leave the block
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_summaries.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_DEFAULT_BASE;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cfg_default_base = value;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value)
			report("default_local_base readback", {32'h0, prdata}, {32'h0, value});
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic push_random_entry();
		logic [7:0]  kind;
		logic [7:0]  len;
		logic [7:0]  min_len;
		logic [95:0] body;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 35)
			kind = KIND_LAPIC;
		else if (pick < 55)
			kind = KIND_IOAPIC;
		else if (pick < 75)
			kind = KIND_LAPIC_OVR;
		else
			kind = 8'($urandom);
		case (kind)
			KIND_LAPIC:     min_len = LEN_LAPIC_MIN;
			KIND_IOAPIC:    min_len = LEN_IOAPIC_MIN;
			KIND_LAPIC_OVR: min_len = LEN_OVR_MIN;
			default:        min_len = LEN_MIN;
		endcase
		pick = $urandom_range(99);
		if (pick < 60)
			len = min_len;
		else if (pick < 80)
			len = 8'($urandom_range(min_len, min_len + 8));
		else if (pick < 95)
			len = 8'($urandom_range(LEN_MIN, min_len));
		else if (pick < 98)
			len = 8'($urandom_range(LEN_MIN, 255));
		else
			len = 8'($urandom_range(0, 1));
		body = {$urandom, $urandom, $urandom};
		// mostly enabled processors
		if (kind == KIND_LAPIC && $urandom_range(99) < 80)
			body[32] = 1'b1;
		push_entry(kind, len, body);
	endtask

	task automatic test_reset_default();
		push_entry(KIND_LAPIC, LEN_LAPIC_MIN, {56'h0, 8'h01, 8'h3c, 24'h0});
		send_table(1'b0);
		drain_results();
	endtask

	task automatic test_processor_entries();
		push_entry(KIND_LAPIC, LEN_LAPIC_MIN, {56'h0, 8'h01, 8'h00, 24'h0});
		push_entry(KIND_LAPIC, LEN_LAPIC_MIN, {56'h0, 8'hfe, 8'hff, 24'h0});
		push_entry(KIND_LAPIC, 8'd7, {56'h0, 8'hff, 8'h55, 24'h0});
		push_entry(KIND_LAPIC, 8'd10, {56'h0, 8'hff, 8'hff, 24'h0});
		send_table(1'b0);
		drain_results();
	endtask

	task automatic test_router_and_override();
		push_entry(KIND_IOAPIC, LEN_IOAPIC_MIN, {32'h0, 32'hffff_ffff, 32'h0});
		push_entry(KIND_IOAPIC, LEN_IOAPIC_MIN, {32'h1234_5678, 32'h9abc_def0, 32'h0});
		push_entry(KIND_LAPIC_OVR, 8'd11, {64'h1111_2222_3333_4444, 32'h0});
		push_entry(KIND_LAPIC_OVR, LEN_OVR_MIN, {64'hffff_ffff_ffff_ffff, 32'h0});
		push_entry(KIND_LAPIC_OVR, LEN_OVR_MIN, {64'h0, 32'h0});
		push_entry(8'd9, LEN_MIN, 96'h0);
		push_entry(8'hff, 8'd5, {$urandom, $urandom, $urandom});
		send_table(1'b1);
		push_entry(KIND_IOAPIC, 8'd11, {32'h5555_aaaa, 32'haaaa_5555, 32'h0});
		send_table(1'b0);
		drain_results();
	endtask

	task automatic test_id_list_full();
		for (int i = 0; i < MAX_IDS_DEF + 2; i++)
			push_entry(KIND_LAPIC, LEN_LAPIC_MIN, {56'h0, 8'h01, 8'(i + 1), 24'h0});
		send_table(1'b1);
		drain_results();
	endtask

	task automatic test_bad_length();
		push_entry(KIND_IOAPIC, 8'd1, 96'h0);
		push_entry(KIND_LAPIC, LEN_LAPIC_MIN, {56'h0, 8'h01, 8'h77, 24'h0});
		send_table(1'b0);
		push_entry(KIND_LAPIC, LEN_LAPIC_MIN, {56'h0, 8'h01, 8'h42, 24'h0});
		push_entry(KIND_LAPIC_OVR, 8'd0, 96'h0);
		push_entry(KIND_LAPIC_OVR, LEN_OVR_MIN, {64'hdead_beef_0000_0001, 32'h0});
		send_table(1'b1);
		drain_results();
	endtask

	task automatic test_truncated_and_empty();
		push_entry(KIND_LAPIC, LEN_LAPIC_MIN, {56'h0, 8'h01, 8'h10, 24'h0});
		push_entry(KIND_IOAPIC, LEN_IOAPIC_MIN, {32'h0000_0020, 32'hfec0_0000, 32'h0});
		repeat (5) void'(table_bytes.pop_back());
		send_table(1'b0);
		// lone type byte, then a bare end marker on an empty table
		table_bytes.push_back(KIND_IOAPIC);
		send_table(1'b0);
		send_table(1'b1);
		// data-less transfers inside an entry
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(LEN_LAPIC_MIN, 1'b1, 1'b0);
		send_item(8'h5a, 1'b0, 1'b0);
		push_entry(KIND_LAPIC, LEN_LAPIC_MIN, {56'h0, 8'h01, 8'h99, 24'h0});
		for (int i = 0; i < 2; i++)
			void'(table_bytes.pop_front());
		send_table(1'b0);
		drain_results();
	endtask

	task automatic test_config_extremes();
		apb_write(32'h0000_0000);
		push_entry(KIND_IOAPIC, LEN_IOAPIC_MIN, {$urandom, $urandom, 32'h0});
		send_table(1'b0);
		drain_results();
		apb_write(32'hffff_ffff);
		push_entry(KIND_LAPIC_OVR, 8'd11, {$urandom, $urandom, 32'h0});
		send_table(1'b1);
		drain_results();
		apb_write($urandom);
		send_table(1'b1);
		drain_results();
	endtask

	task automatic test_random();
		int start;
		int tables;
		int n;
		start  = bytes_sent;
		tables = 0;
		while (bytes_sent - start < RANDOM_BYTES) begin
			// hold a stretch with no stalls on either side
			if (bytes_sent - start >= 700 && bytes_sent - start < 1000)
				stall_pct = 0;
			else
				stall_pct = 15;
			if ($urandom_range(99) < 8) begin
				repeat ($urandom_range(1, 30))
					table_bytes.push_back(8'($urandom));
			end else begin
				n = $urandom_range(0, 10);
				repeat (n) push_random_entry();
				if (table_bytes.size() > 0 && $urandom_range(99) < 12)
					repeat ($urandom_range(1, table_bytes.size() < 12 ? table_bytes.size() : 12))
						void'(table_bytes.pop_back());
			end
			send_table($urandom_range(99) < 30);
			tables++;
			if (tables % 30 == 0) begin
				drain_results();
				case ($urandom_range(3))
					0:       apb_write(32'h0000_0000);
					1:       apb_write(32'hffff_ffff);
					default: apb_write($urandom);
				endcase
			end
		end
		stall_pct = 15;
		drain_results();
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : check_summary
		summary_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_summaries.size() == 0) begin
				report("unexpected summary", {63'h0, status}, 64'h0);
			end else begin
				want = pending_summaries.pop_front();
				if (status !== want.status)
					report("status", {63'h0, status}, {63'h0, want.status});
				if (local_base !== want.local_base)
					report("local_base", local_base, want.local_base);
				if (router_base !== want.router_base)
					report("router_base", {32'h0, router_base}, {32'h0, want.router_base});
				if (router_irq_base !== want.router_irq_base)
					report("router_irq_base", {32'h0, router_irq_base},
						{32'h0, want.router_irq_base});
				if (cpu_count !== want.cpu_count)
					report("cpu_count", 64'(cpu_count), 64'(want.cpu_count));
				if (cpu_ids !== want.cpu_ids)
					report("cpu_ids", cpu_ids, want.cpu_ids);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_default();
		test_processor_entries();
		test_router_and_override();
		test_id_list_full();
		test_bad_length();
		test_truncated_and_empty();
		test_config_extremes();
		test_random();
		if (mismatches == 0 && pending_summaries.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/madt_pkg.sv
hw/rtl/madt_entry_seq.sv
hw/rtl/madt_accum.sv
hw/rtl/madt_entry_parser_top.sv
tb/sv/tb_madt_entry_parser_top.sv
